>>> src/c8x_pkg.sv
// Shared types and constants for the CHIP-8 execute core.
package c8x_pkg;
    localparam int MEM_BYTES     = 4096;
    localparam int STACK_DEPTH_D = 16;
    localparam int SCR_H         = 32;
    localparam logic [11:0] START_RESET = 12'd512;

    localparam logic [1:0] REQ_EXEC  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_ROW   = 2'd3;

    localparam logic [1:0] ADDR_START = 2'd0;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DEC   = 9'b000000010,
        S_MEMRD = 9'b000000100,
        S_MEMWT = 9'b000001000,
        S_DRAW  = 9'b000010000,
        S_CLR   = 9'b000100000,
        S_BCD   = 9'b001000000,
        S_STORE = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    // Memory request from the sequencer to the RAM.
    typedef struct packed {
        logic        we;
        logic [11:0] addr;
        logic [7:0]  wdata;
    } t_mem_req;
endpackage

>>> src/c8x_ram.sv
// Byte-wide main memory with one registered read port.
module c8x_ram (
    input  logic              i_clk,
    input  c8x_pkg::t_mem_req i_req,
    output logic [7:0]        o_rdata
);
    import c8x_pkg::*;
    logic [7:0] r_mem [MEM_BYTES];

    // Read one byte a cycle, and write one byte too when enabled
    always_ff @(posedge i_clk) begin
        if (i_req.we) r_mem[i_req.addr] <= i_req.wdata;
        o_rdata <= r_mem[i_req.addr];
    end
endmodule

>>> src/chip8_instruction_execute_core.sv
// Top level of the CHIP-8 execute core: sequencer, registers and frame buffer.
// Each item goes from idle through decode to done, where its result is posted.
// A memory read passes through the MEMRD and MEMWT states on the way. 00E0
// clears the frame rows in turn; DXYN reads and draws each sprite row, FX65
// reads each register from memory and FX55 writes each register to it. FX33
// subtracts one hundred or ten per step, takes one more step, then writes its
// three digits. After reset the frame buffer is cleared before the first item
// is taken. The memory has one port, which sets the per-byte cost. Ready is high
// only while the sequencer is idle; the result is held until taken.
module chip8_instruction_execute_core #(
    parameter int STACK_DEPTH = c8x_pkg::STACK_DEPTH_D
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] req_type
    input  logic [1:0]  s_axis_tuser,
    // [15:0] instruction, [31:16] keys, [39:32] random_byte, [51:40] address,
    // [59:52] write_byte, [64:60] row_index, zero fill
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [11:0] pc, [12] waiting_key, [13] screen_changed, [21:14] read_byte,
    // [85:22] row_bits, zero fill
    output logic [87:0] m_axis_tdata
);
    import c8x_pkg::*;
    localparam int SPW = $clog2(STACK_DEPTH);

    t_state r_st;
    logic [11:0] r_start, r_pc, r_i;
    logic [7:0]  r_v [16];
    logic [SPW-1:0] r_sp;
    logic [11:0] r_stk [STACK_DEPTH];
    logic [7:0]  r_dt, r_stm;
    logic [63:0] r_fb [SCR_H];
    logic        r_wait;
    logic [15:0] r_prev;
    logic [1:0]  r_req;
    logic [15:0] r_op, r_keys;
    logic [7:0]  r_rnd, r_wb, r_rb;
    logic [11:0] r_addr;
    logic [4:0]  r_row;
    logic [4:0]  r_cnt;
    logic [5:0]  r_x0;
    logic [4:0]  r_y0;
    logic [7:0]  r_acc;
    logic [3:0]  r_hund, r_tens;
    logic        r_chg;
    logic [63:0] r_rowbits;
    logic        r_flag;
    t_mem_req    mreq;
    logic [7:0]  mrd;

    c8x_ram u_ram (.i_clk(i_clk), .i_req(mreq), .o_rdata(mrd));

    logic [3:0] ox, oy, on;
    logic [7:0] nn, vx, vy;
    logic [8:0] sum;
    assign ox = r_op[11:8];
    assign oy = r_op[7:4];
    assign on = r_op[3:0];
    assign nn = r_op[7:0];
    assign vx = r_v[ox];
    assign vy = r_v[oy];

    // Stack pointer steps, wrapping at the stack depth
    logic [SPW-1:0] sp_inc, sp_dec;
    assign sp_inc = (r_sp == SPW'(STACK_DEPTH - 1)) ? '0 : r_sp + 1'b1;
    assign sp_dec = (r_sp == '0) ? SPW'(STACK_DEPTH - 1) : r_sp - 1'b1;

    assign pready = 1'b1;
    assign prdata = {20'd0, r_start};
    assign s_axis_tready = (r_st == S_IDLE) && !m_axis_tvalid;

    // Memory address, write enable and write data for the current step
    always_comb begin
        mreq = '{we: 1'b0, addr: r_i + {7'd0, r_cnt}, wdata: 8'd0};
        case (r_st)
            S_MEMRD: if (r_req == REQ_READ) mreq.addr = r_addr;
            S_DEC: if (r_req == REQ_WRITE)
                mreq = '{we: 1'b1, addr: r_addr, wdata: r_wb};
            S_STORE: begin
                mreq.we = 1'b1;
                mreq.wdata = r_v[r_cnt[3:0]];
            end
            S_BCD: if (r_acc < 8'd10 && r_flag) begin
                mreq.we = 1'b1;
                mreq.wdata = {4'd0, r_cnt == 5'd0 ? r_hund :
                              r_cnt == 5'd1 ? r_tens : r_acc[3:0]};
            end
            default: ;
        endcase
    end

    // Sprite row shifted to the draw column
    logic [63:0] spr, row_old;
    logic [127:0] spr2;
    logic [4:0]  drow;
    assign drow = r_y0 + r_cnt;
    assign spr2 = {56'd0, mrd[0], mrd[1], mrd[2], mrd[3], mrd[4], mrd[5], mrd[6],
                   mrd[7], 64'd0} >> (7'd64 - {1'b0, r_x0});
    assign spr = spr2[63:0] | spr2[127:64];
    assign row_old = r_fb[drow];

    // Lowest newly pressed key, with the rule for recorded keys
    logic        kfound;
    logic [3:0]  kidx;
    logic [15:0] knew;
    always_comb begin
        kfound = 1'b0;
        kidx = 4'd0;
        knew = r_keys & ~r_prev;
        for (int k = 15; k >= 0; k--)
            if (knew[k]) begin
                kfound = 1'b1;
                kidx = 4'(k);
            end
    end

    logic down;
    assign down = (vx < 8'd16) && r_keys[vx[3:0]];
    assign sum = {1'b0, vx} + {1'b0, (r_op[15:12] == 4'h8 && on == 4'h5) ? ~vy :
                 (r_op[15:12] == 4'h8 && on == 4'h7) ? ~vx : vy} +
                 ((r_op[15:12] == 4'h8 && (on == 4'h5 || on == 4'h7)) ? 9'd1 : 9'd0);

    // Sequencer and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_cnt <= '0; r_start <= START_RESET; r_pc <= START_RESET;
            r_i <= '0; r_sp <= '0; r_dt <= '0; r_stm <= '0; r_wait <= 1'b0;
            r_prev <= '0; m_axis_tvalid <= 1'b0; r_flag <= 1'b0;
            for (int k = 0; k < 16; k++) r_v[k] <= '0;
        end else begin
            if (psel && penable && pwrite && paddr == ADDR_START)
                r_start <= pwdata[11:0];
            if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
            case (r_st)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_req <= s_axis_tuser; r_op <= s_axis_tdata[15:0];
                    r_keys <= s_axis_tdata[31:16]; r_rnd <= s_axis_tdata[39:32];
                    r_addr <= s_axis_tdata[51:40]; r_wb <= s_axis_tdata[59:52];
                    r_row <= s_axis_tdata[64:60];
                    r_chg <= 1'b0; r_rb <= '0; r_rowbits <= '0; r_cnt <= '0;
                    r_flag <= 1'b1;
                    r_st <= S_DEC;
                end
                S_DEC: begin
                    r_st <= S_DONE;
                    if (r_req == REQ_READ) r_st <= S_MEMRD;
                    else if (r_req == REQ_ROW) r_rowbits <= r_fb[r_row];
                    else if (r_req == REQ_EXEC && !(r_wait && (r_op & 16'hF0FF) != 16'hF00A)) begin
                        if (!(r_op[15:12] == 4'hF && nn == 8'h0A)) begin
                            r_pc <= r_pc + 12'd2;
                            if (r_dt != 0) r_dt <= r_dt - 8'd1;
                            if (r_stm != 0) r_stm <= r_stm - 8'd1;
                        end
                        case (r_op[15:12])
                            4'h0: if (r_op == 16'h00E0) begin
                                r_chg <= 1'b1; r_cnt <= '0; r_st <= S_CLR;
                            end else if (r_op == 16'h00EE) begin
                                r_sp <= sp_dec;
                                r_pc <= r_stk[sp_dec] + 12'd2;
                            end
                            4'h1: r_pc <= r_op[11:0];
                            4'h2: begin
                                r_stk[r_sp] <= r_pc; r_sp <= sp_inc;
                                r_pc <= r_op[11:0];
                            end
                            4'h3: if (vx == nn) r_pc <= r_pc + 12'd4;
                            4'h4: if (vx != nn) r_pc <= r_pc + 12'd4;
                            4'h5: if (on == 0 && vx == vy) r_pc <= r_pc + 12'd4;
                            4'h6: r_v[ox] <= nn;
                            4'h7: r_v[ox] <= vx + nn;
                            4'h8: begin
                                case (on)
                                    4'h0: r_v[ox] <= vy;
                                    4'h1: r_v[ox] <= vx | vy;
                                    4'h2: r_v[ox] <= vx & vy;
                                    4'h3: r_v[ox] <= vx ^ vy;
                                    4'h4: begin r_v[15] <= {7'd0, sum[8]};
                                        r_v[ox] <= sum[7:0]; end
                                    4'h5: begin r_v[15] <= {7'd0, vx > vy};
                                        r_v[ox] <= sum[7:0]; end
                                    4'h6: begin r_v[15] <= {7'd0, vx[0]};
                                        r_v[ox] <= vx >> 1; end
                                    4'h7: begin r_v[15] <= {7'd0, vy > vx};
                                        r_v[ox] <= vy - vx; end
                                    4'hE: begin r_v[15] <= {7'd0, vx[7]};
                                        r_v[ox] <= vx << 1; end
                                    default: ;
                                endcase
                            end
                            4'h9: if (on == 0 && vx != vy) r_pc <= r_pc + 12'd4;
                            4'hA: r_i <= r_op[11:0];
                            4'hB: r_pc <= r_op[11:0] + {4'd0, r_v[0]};
                            4'hC: r_v[ox] <= nn & r_rnd;
                            4'hD: begin
                                r_chg <= 1'b1; r_x0 <= vx[5:0]; r_y0 <= vy[4:0];
                                r_v[15] <= '0;
                                if (on != 0) r_st <= S_MEMRD;
                            end
                            4'hE: begin
                                if (nn == 8'h9E && down) r_pc <= r_pc + 12'd4;
                                if (nn == 8'hA1 && !down) r_pc <= r_pc + 12'd4;
                            end
                            default: case (nn)
                                8'h07: r_v[ox] <= r_dt;
                                8'h0A: if (!r_wait) begin
                                    r_wait <= 1'b1; r_prev <= r_keys;
                                end else if (kfound) begin
                                    r_v[ox] <= {4'd0, kidx}; r_wait <= 1'b0;
                                    r_prev <= (r_prev & ~((16'd1 << kidx) - 16'd1)) |
                                              (r_keys & ((16'd1 << kidx) - 16'd1));
                                    r_pc <= r_pc + 12'd2;
                                    if (r_dt != 0) r_dt <= r_dt - 8'd1;
                                    if (r_stm != 0) r_stm <= r_stm - 8'd1;
                                end else r_prev <= r_keys;
                                // the new value still counts down for this instruction
                                8'h15: r_dt <= (vx != 8'd0) ? vx - 8'd1 : 8'd0;
                                8'h18: r_stm <= (vx != 8'd0) ? vx - 8'd1 : 8'd0;
                                8'h1E: r_i <= r_i + {4'd0, vx};
                                8'h29: r_i <= {4'd0, vx} * 12'd5;
                                8'h33: begin
                                    r_acc <= vx; r_hund <= '0; r_tens <= '0;
                                    r_flag <= 1'b0; r_st <= S_BCD;
                                end
                                8'h55: r_st <= S_STORE;
                                8'h65: r_st <= S_MEMRD;
                                default: ;
                            endcase
                        endcase
                    end
                end
                S_MEMRD: r_st <= S_MEMWT;
                S_MEMWT: begin
                    if (r_req == REQ_READ) begin
                        r_rb <= mrd; r_st <= S_DONE;
                    end else if (r_op[15:12] == 4'hD) begin
                        r_fb[drow] <= row_old ^ spr;
                        if ((row_old & spr) != 0) r_v[15] <= 8'd1;
                        r_cnt <= r_cnt + 1'b1;
                        r_st <= (r_cnt + 1'b1 == {1'b0, on}) ? S_DONE : S_MEMRD;
                    end else begin
                        r_v[r_cnt[3:0]] <= mrd;
                        r_cnt <= r_cnt + 1'b1;
                        r_st <= (r_cnt[3:0] == ox) ? S_DONE : S_MEMRD;
                    end
                end
                S_STORE: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt[3:0] == ox) r_st <= S_DONE;
                end
                S_BCD: begin
                    // Take off hundreds, then tens, then write the three digits
                    if (!r_flag) begin
                        if (r_acc >= 8'd100) begin
                            r_acc <= r_acc - 8'd100; r_hund <= r_hund + 1'b1;
                        end else if (r_acc >= 8'd10) begin
                            r_acc <= r_acc - 8'd10; r_tens <= r_tens + 1'b1;
                        end else r_flag <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == 5'd2) r_st <= S_DONE;
                    end
                end
                S_CLR: begin
                    r_fb[r_cnt] <= '0;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'(SCR_H - 1)) r_st <= r_flag ? S_DONE : S_IDLE;
                end
                S_DONE: begin
                    m_axis_tvalid <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tdata = {2'd0, r_rowbits, r_rb, r_chg, r_wait, r_pc};
endmodule

>>> src/c8x_checker.sv
// Port-level assertions for the execute core, bound to the top level.
module c8x_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata
);
    // No new item while a result is pending
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");
    // An accepted item blocks the next cycle
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("back to back accept");
    // A waiting result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
endmodule

bind chip8_instruction_execute_core c8x_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
